// ===== rtl/core/mtk_pkg.sv =====
// Shared types, constants and helpers for the feedback-queue tick accounting core.
// No dependencies; every other file of the core but mtk_checker imports this package.
package mtk_pkg;

	// Table geometry
	localparam int SLOTS  = 64;
	localparam int LEVELS = 4;
	localparam int IDX_W  = $clog2(SLOTS);

	// Field widths fixed by the item formats
	localparam int SLOT_W  = 6;
	localparam int LEVEL_W = 2;
	localparam int CNT_W   = 8;
	localparam int CFG_IDX_W = 3;

	// Deepest level a slot may sit at
	localparam logic [LEVEL_W-1:0] LOWEST_LEVEL = LEVEL_W'((LEVELS - 1 > 3) ? 3 : LEVELS - 1);

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// Register reset values
	localparam logic [CNT_W-1:0] SLICE0_RST = 8'd1;
	localparam logic [CNT_W-1:0] SLICE1_RST = 8'd3;
	localparam logic [CNT_W-1:0] SLICE2_RST = 8'd9;
	localparam logic [CNT_W-1:0] SLICE3_RST = 8'd15;
	localparam logic [CNT_W-1:0] AGING_RST  = 8'd30;

	// Register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] CFG_SLICE0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLICE1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SLICE2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SLICE3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_AGING  = 3'd4;

	typedef enum logic [1:0] {
		REQ_TICK   = 2'd0,
		REQ_STATUS = 2'd1,
		REQ_LOAD   = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		CAUSE_NONE    = 2'd0,
		CAUSE_EXPIRED = 2'd1,
		CAUSE_HIGHER  = 2'd2
	} cause_t;

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} state_t;

	// One task slot as it travels along the cell chain
	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               runnable;
		logic [CNT_W-1:0]   slice;
		logic [CNT_W-1:0]   age;
	} slot_rec_t;

	// Latched request under service
	typedef struct packed {
		logic [1:0]         req;
		logic [SLOT_W-1:0]  slot;
		logic               running_valid;
		logic               runnable;
		logic [LEVEL_W-1:0] load_level;
	} op_t;

	// Configuration registers
	typedef struct packed {
		logic [3:0][CNT_W-1:0] slice;
		logic [CNT_W-1:0]      aging;
	} cfg_t;

	// What the head unit reports for the slot under it
	typedef struct packed {
		logic               running_hit;
		logic               expired;
		logic [LEVEL_W-1:0] run_level;
		logic               other_hit;
		logic [LEVEL_W-1:0] other_level;
	} head_stat_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + CNT_W'(1);
	endfunction

endpackage

// ===== rtl/core/mtk_cell.sv =====
// One storage cell of the slot chain: holds a single slot record.
// Depends on mtk_pkg for the record type.
module mtk_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              shift_en,
	input  mtk_pkg::slot_rec_t rec_in,
	output mtk_pkg::slot_rec_t rec_q
);
	import mtk_pkg::*;

	// Take the neighbor's record on every step of a walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
		end else if (shift_en) begin
			rec_q <= rec_in;
		end
	end

endmodule

// ===== rtl/core/mtk_head.sv =====
// Update unit at the head of the slot chain: applies one request to one slot record.
// Depends on mtk_pkg for record, request and configuration types.
module mtk_head (
	input  mtk_pkg::op_t             op,
	input  mtk_pkg::cfg_t            cfg,
	input  logic [mtk_pkg::IDX_W-1:0] idx,
	input  mtk_pkg::slot_rec_t       rec_in,
	output mtk_pkg::slot_rec_t       rec_out,
	output mtk_pkg::head_stat_t      stat
);
	import mtk_pkg::*;

	logic               slot_ok;
	logic               match;
	logic [CNT_W-1:0]   slice_nx;
	logic [CNT_W-1:0]   age_nx;
	logic [LEVEL_W-1:0] lvl;
	logic               exp;

	assign slot_ok = 32'(op.slot) < SLOTS;
	assign match   = slot_ok && (32'(op.slot) == 32'(idx));
	assign slice_nx = sat_inc(rec_in.slice);
	assign age_nx   = sat_inc(rec_in.age);
	assign lvl      = rec_in.level;
	assign exp      = slice_nx >= cfg.slice[lvl];

	// Apply the request to the record under the head
	always_comb begin
		rec_out = rec_in;
		stat    = '0;
		unique case (op.req)
			REQ_STATUS: begin
				if (match) begin
					rec_out.runnable = op.runnable;
				end
			end
			REQ_LOAD: begin
				if (match) begin
					rec_out.level = (op.load_level > LOWEST_LEVEL) ? LOWEST_LEVEL : op.load_level;
					rec_out.slice = '0;
					rec_out.age   = '0;
				end
			end
			REQ_TICK: begin
				if (op.running_valid && slot_ok) begin
					if (match) begin
						// Running slot: count its slice, demote on expiry
						stat.running_hit = 1'b1;
						rec_out.age      = '0;
						rec_out.slice    = slice_nx;
						stat.run_level   = lvl;
						if (exp) begin
							stat.expired   = 1'b1;
							rec_out.slice  = '0;
							if (lvl < LOWEST_LEVEL) begin
								rec_out.level  = lvl + LEVEL_W'(1);
								stat.run_level = lvl + LEVEL_W'(1);
							end
						end
					end else if (!rec_in.runnable) begin
						rec_out.age = '0;
					end else begin
						// Waiting slot: age, promote at threshold
						rec_out.age = age_nx;
						if (age_nx >= cfg.aging && lvl != '0) begin
							rec_out.level = lvl - LEVEL_W'(1);
							rec_out.slice = '0;
							rec_out.age   = '0;
						end
						stat.other_hit   = 1'b1;
						stat.other_level = rec_out.level;
					end
				end
			end
			default: begin
				rec_out = rec_in;
			end
		endcase
	end

endmodule

// ===== rtl/core/mlfq_tick_accounting_core.sv =====
// Top level of the feedback-queue tick accounting core: slot chain, head unit, control.
// Depends on mtk_pkg, mtk_cell and mtk_head.
//
//   channel   direction  beat carries
//   s_axis    in         tuser: req_type; tdata: slot, running_valid, runnable, load_level
//   m_axis    out        tdata: preempt, preempt_cause, running_level
//   cfg       in         cfg_index, cfg_data (register write)
//
// Every request walks the whole slot chain once, passing each record in turn through
// the one head unit.
// The next request can be taken in the cycle after the result is registered.
// Reset puts all slot records to zero and the registers to their defaults at once.
// A result not yet taken holds the next walk on its final step.
module mlfq_tick_accounting_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [5:0] slot, [6] running_valid, [7] runnable,
	                                    // [9:8] load_level, [15:10] zero
	input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [0] preempt, [2:1] preempt_cause,
	                                    // [4:3] running_level, [7:5] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import mtk_pkg::*;

	state_t             state_q, state_nx;
	op_t                op_q;
	cfg_t               cfg_q;
	logic [IDX_W-1:0]   idx_q;
	logic               last;
	logic               accept;
	logic               shift_en;
	logic               out_valid_q;
	logic [4:0]         out_q;
	logic               exp_q, exp_nx;
	logic [LEVEL_W-1:0] rlvl_q, rlvl_nx;
	logic               have_q, have_nx;
	logic [LEVEL_W-1:0] min_q, min_nx;
	logic               tick_act;
	slot_rec_t          chain [SLOTS];
	slot_rec_t          head_out;
	head_stat_t         stat;

	assign cfg_ready     = 1'b1;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign last          = idx_q == IDX_W'(SLOTS - 1);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_q};
	assign tick_act      = (op_q.req == REQ_TICK) && op_q.running_valid
	                       && (32'(op_q.slot) < SLOTS);

	// Cell chain: each cell takes its upper neighbor, the tail takes the head result
	for (genvar k = 0; k < SLOTS; k++) begin : g_cell
		if (k == SLOTS - 1) begin : g_tail
			mtk_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (shift_en),
				.rec_in   (head_out),
				.rec_q    (chain[k])
			);
		end else begin : g_body
			mtk_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (shift_en),
				.rec_in   (chain[k+1]),
				.rec_q    (chain[k])
			);
		end
	end

	mtk_head u_head (
		.op      (op_q),
		.cfg     (cfg_q),
		.idx     (idx_q),
		.rec_in  (chain[0]),
		.rec_out (head_out),
		.stat    (stat)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state and handshake
	always_comb begin
		state_nx      = state_q;
		s_axis_tready = 1'b0;
		shift_en      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_nx = ST_WALK;
				end
			end
			ST_WALK: begin
				shift_en = !(last && out_valid_q && !m_axis_tready);
				if (shift_en && last) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// Latch the request payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q.req           <= s_axis_tuser;
			op_q.slot          <= s_axis_tdata[5:0];
			op_q.running_valid <= s_axis_tdata[6];
			op_q.runnable      <= s_axis_tdata[7];
			op_q.load_level    <= s_axis_tdata[9:8];
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slice[0] <= SLICE0_RST;
			cfg_q.slice[1] <= SLICE1_RST;
			cfg_q.slice[2] <= SLICE2_RST;
			cfg_q.slice[3] <= SLICE3_RST;
			cfg_q.aging    <= AGING_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SLICE0: cfg_q.slice[0] <= cfg_data;
				CFG_SLICE1: cfg_q.slice[1] <= cfg_data;
				CFG_SLICE2: cfg_q.slice[2] <= cfg_data;
				CFG_SLICE3: cfg_q.slice[3] <= cfg_data;
				CFG_AGING:  cfg_q.aging    <= cfg_data;
				default:    cfg_q.aging    <= cfg_q.aging;
			endcase
		end
	end

	// Fold the head report into the running summary
	always_comb begin
		exp_nx  = exp_q;
		rlvl_nx = rlvl_q;
		if (stat.running_hit) begin
			exp_nx  = stat.expired;
			rlvl_nx = stat.run_level;
		end
		have_nx = have_q || stat.other_hit;
		min_nx  = min_q;
		if (stat.other_hit && (!have_q || stat.other_level < min_q)) begin
			min_nx = stat.other_level;
		end
	end

	// Step counter and summary registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			exp_q  <= 1'b0;
			rlvl_q <= '0;
			have_q <= 1'b0;
			min_q  <= '0;
		end else if (accept) begin
			idx_q  <= '0;
			exp_q  <= 1'b0;
			rlvl_q <= '0;
			have_q <= 1'b0;
			min_q  <= '0;
		end else if (shift_en) begin
			idx_q  <= last ? '0 : idx_q + IDX_W'(1);
			exp_q  <= exp_nx;
			rlvl_q <= rlvl_nx;
			have_q <= have_nx;
			min_q  <= min_nx;
		end
	end

	// Output register: load on the final step, drop on the taken beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (shift_en && last) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en && last) begin
			if (!tick_act) begin
				out_q <= {2'b00, CAUSE_NONE, 1'b0};
			end else if (exp_nx) begin
				out_q <= {rlvl_nx, CAUSE_EXPIRED, 1'b1};
			end else if (have_nx && min_nx < rlvl_nx) begin
				out_q <= {rlvl_nx, CAUSE_HIGHER, 1'b1};
			end else begin
				out_q <= {rlvl_nx, CAUSE_NONE, 1'b0};
			end
		end
	end

endmodule

// ===== rtl/core/mtk_checker.sv =====
// Port-level checks for the feedback-queue tick accounting core, bound to its top level.
// Depends on mlfq_tick_accounting_core port names only.
module mtk_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata
);

	// A stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	// Preempt flag agrees with the cause
	a_cause_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[2:1] != 2'd0)))
		else $error("preempt flag and cause disagree");

	// Cause code three never appears
	a_cause_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[2:1] != 2'd3)
		else $error("invalid preempt cause");

	// The table walk keeps the input closed after a taken beat
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted during a walk");

endmodule

bind mlfq_tick_accounting_core mtk_checker u_mtk_checker (.*);

// ===== sim/tb_mlfq_tick_accounting_core.sv =====
// Self-checking testbench for the feedback-queue tick accounting core.
// Drives request beats from a queue, predicts each result in a local scheduler model.
// Depends on mtk_pkg and mlfq_tick_accounting_core.
`timescale 1ns / 100ps

module tb_mlfq_tick_accounting_core;
	import mtk_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int LIMIT_CYCLES = 1000000;
	localparam int HOLD_CYCLES = 600;

	typedef struct packed {
		logic [1:0]         req;
		logic [SLOT_W-1:0]  slot;
		logic               rv;
		logic               rn;
		logic [LEVEL_W-1:0] ll;
	} sched_beat_t;

	typedef struct packed {
		logic               preempt;
		cause_t             cause;
		logic [LEVEL_W-1:0] level;
	} verdict_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;

	mlfq_tick_accounting_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	// Local copy of the slot table and the policy registers
	logic [LEVEL_W-1:0] lvl_tab   [SLOTS] = '{default: '0};
	logic               run_tab   [SLOTS] = '{default: 1'b0};
	logic [CNT_W-1:0]   slice_tab [SLOTS] = '{default: '0};
	logic [CNT_W-1:0]   age_tab   [SLOTS] = '{default: '0};
	logic [CNT_W-1:0]   slice_cfg [4] = '{SLICE0_RST, SLICE1_RST, SLICE2_RST, SLICE3_RST};
	logic [CNT_W-1:0]   age_thr = AGING_RST;

	sched_beat_t pend_q[$];
	verdict_t    verdict_q[$];
	sched_beat_t cur_beat;
	verdict_t    want;
	int          n_sent = 0;
	int          n_done = 0;
	int          errors = 0;
	int          idle_pct = 0;
	int          tx_gap = 0;
	int          rx_gap = 0;
	int          cycles = 0;
	bit          pressure_go = 1'b0;
	bit          hold_done = 1'b0;
	logic        hold_rx = 1'b0;
	int          hold_cnt = 0;

	function automatic logic [CNT_W-1:0] bump8(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + 8'd1;
	endfunction

	// Apply one request to the local table and return the verdict it yields
	function automatic verdict_t account_beat(input sched_beat_t b);
		verdict_t r;
		logic [LEVEL_W-1:0] lv;
		logic expired;
		int s;
		r = '{preempt: 1'b0, cause: CAUSE_NONE, level: '0};
		s = int'(b.slot);
		if (s < SLOTS) begin
			case (b.req)
				REQ_STATUS: run_tab[s] = b.rn;
				REQ_LOAD: begin
					lvl_tab[s] = (b.ll > LOWEST_LEVEL) ? LOWEST_LEVEL : b.ll;
					slice_tab[s] = '0;
					age_tab[s] = '0;
				end
				REQ_TICK: if (b.rv) begin
					// age every waiting slot, promote those at the threshold
					for (int i = 0; i < SLOTS; i++) begin
						if (i == s || !run_tab[i]) begin
							age_tab[i] = '0;
						end else begin
							age_tab[i] = bump8(age_tab[i]);
							if (age_tab[i] >= age_thr && lvl_tab[i] != '0) begin
								lvl_tab[i] = lvl_tab[i] - LEVEL_W'(1);
								slice_tab[i] = '0;
								age_tab[i] = '0;
							end
						end
					end
					// charge the running slot, demote on slice expiry
					slice_tab[s] = bump8(slice_tab[s]);
					lv = lvl_tab[s];
					expired = (slice_tab[s] >= slice_cfg[lv]);
					if (expired) begin
						if (lv < LOWEST_LEVEL)
							lv = lv + LEVEL_W'(1);
						lvl_tab[s] = lv;
						slice_tab[s] = '0;
						age_tab[s] = '0;
						r.preempt = 1'b1;
						r.cause = CAUSE_EXPIRED;
					end else begin
						for (int i = 0; i < SLOTS; i++) begin
							if (i != s && run_tab[i] && lvl_tab[i] < lv) begin
								r.preempt = 1'b1;
								r.cause = CAUSE_HIGHER;
							end
						end
					end
					r.level = lv;
				end
				default: ;
			endcase
		end
		return r;
	endfunction

	task automatic queue_beat(input logic [1:0] req, input int slot, input logic rv,
	                          input logic rn, input logic [1:0] ll);
		sched_beat_t b;
		b.req = req;
		b.slot = SLOT_W'(slot);
		b.rv = rv;
		b.rn = rn;
		b.ll = ll;
		pend_q.push_back(b);
		n_sent++;
	endtask

	// Random traffic around a small window of slots so that they interact
	task automatic queue_random(input int n);
		int base;
		int pick;
		base = 0;
		for (int k = 0; k < n; k++) begin
			if (k % 60 == 0)
				base = $urandom_range(SLOTS - 1);
			pick = $urandom_range(99);
			if (pick < 58)
				queue_beat(REQ_TICK, base + $urandom_range(7), 1'b1, 1'($urandom_range(1)),
				           2'($urandom_range(3)));
			else if (pick < 62)
				queue_beat(REQ_TICK, $urandom_range(SLOTS - 1), 1'b0, 1'($urandom_range(1)),
				           2'($urandom_range(3)));
			else if (pick < 82)
				queue_beat(REQ_STATUS, base + $urandom_range(7), 1'b0,
				           ($urandom_range(9) < 7), 2'($urandom_range(3)));
			else if (pick < 95)
				queue_beat(REQ_LOAD, base + $urandom_range(7), 1'($urandom_range(1)),
				           1'($urandom_range(1)), 2'($urandom_range(3)));
			else
				queue_beat(REQ_UNUSED, $urandom_range(SLOTS - 1), 1'($urandom_range(1)),
				           1'($urandom_range(1)), 2'($urandom_range(3)));
		end
	endtask

	task automatic drain();
		while (n_done != n_sent)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_AGING)
			age_thr = val;
		else
			slice_cfg[idx[1:0]] = val;
	endtask

	task automatic set_policy(input logic [7:0] s0, input logic [7:0] s1, input logic [7:0] s2,
	                          input logic [7:0] s3, input logic [7:0] thr);
		write_reg(CFG_SLICE0, s0);
		write_reg(CFG_SLICE1, s1);
		write_reg(CFG_SLICE2, s2);
		write_reg(CFG_SLICE3, s3);
		write_reg(CFG_AGING, thr);
	endtask

	// Sender: offer queued beats, hold until accepted, insert idle bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				verdict_q.push_back(account_beat(cur_beat));
			if (s_axis_tvalid && !s_axis_tready) begin
				// hold the beat
			end else if (tx_gap > 0) begin
				s_axis_tvalid <= 1'b0;
				tx_gap--;
			end else if (pend_q.size() == 0) begin
				s_axis_tvalid <= 1'b0;
			end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
				s_axis_tvalid <= 1'b0;
				tx_gap = $urandom_range(10);
			end else begin
				cur_beat = pend_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {6'b0, cur_beat.ll, cur_beat.rn, cur_beat.rv, cur_beat.slot};
				s_axis_tuser <= cur_beat.req;
			end
		end
	end

	// Long receiver hold-off so the core backs up into its input
	always @(posedge clk) begin
		if (pressure_go && !hold_done) begin
			if (hold_cnt == HOLD_CYCLES) begin
				hold_rx <= 1'b0;
				hold_done <= 1'b1;
			end else begin
				hold_rx <= 1'b1;
				hold_cnt <= hold_cnt + 1;
			end
		end
	end

	// Receiver: check each result beat against the oldest verdict, stall at random
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (verdict_q.size() == 0) begin
				errors++;
				$display("%0t: result beat %h with no verdict pending", $time, m_axis_tdata);
			end else begin
				want = verdict_q.pop_front();
				if (m_axis_tdata[0] !== want.preempt) begin
					errors++;
					$display("%0t: preempt expected %0d actual %0d", $time, want.preempt,
					         m_axis_tdata[0]);
				end
				if (m_axis_tdata[2:1] !== want.cause) begin
					errors++;
					$display("%0t: preempt_cause expected %0d actual %0d", $time, want.cause,
					         m_axis_tdata[2:1]);
				end
				if (m_axis_tdata[4:3] !== want.level) begin
					errors++;
					$display("%0t: running_level expected %0d actual %0d", $time, want.level,
					         m_axis_tdata[4:3]);
				end
				n_done++;
			end
		end
		if (!arst_n || hold_rx) begin
			m_axis_tready <= 1'b0;
		end else if (rx_gap > 0) begin
			m_axis_tready <= 1'b0;
			rx_gap--;
		end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			m_axis_tready <= 1'b0;
			rx_gap = $urandom_range(10);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("tb_mlfq_tick_accounting_core failed");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: register defaults, table extremes, both preemption causes
		idle_pct = 20;
		queue_beat(REQ_TICK, 0, 1'b0, 1'b1, 2'd3);         // no running slot
		queue_beat(REQ_UNUSED, 63, 1'b1, 1'b1, 2'd3);      // unused request type
		queue_beat(REQ_LOAD, 63, 1'b1, 1'b1, 2'd3);
		queue_beat(REQ_LOAD, 0, 1'b0, 1'b0, 2'd0);
		queue_beat(REQ_LOAD, 1, 1'b0, 1'b0, 2'd2);
		queue_beat(REQ_LOAD, 2, 1'b0, 1'b0, 2'd1);
		queue_beat(REQ_STATUS, 63, 1'b0, 1'b1, 2'd0);
		queue_beat(REQ_STATUS, 1, 1'b0, 1'b1, 2'd0);
		queue_beat(REQ_STATUS, 0, 1'b0, 1'b1, 2'd0);
		queue_beat(REQ_TICK, 0, 1'b1, 1'b0, 2'd0);         // level-0 slice expires
		queue_beat(REQ_TICK, 63, 1'b1, 1'b0, 2'd0);        // higher slot waits
		queue_beat(REQ_TICK, 2, 1'b1, 1'b0, 2'd0);
		queue_beat(REQ_TICK, 2, 1'b1, 1'b0, 2'd0);
		queue_beat(REQ_LOAD, 0, 1'b0, 1'b0, 2'd0);
		queue_beat(REQ_TICK, 2, 1'b1, 1'b0, 2'd0);         // expiry with higher waiting
		queue_beat(REQ_STATUS, 0, 1'b0, 1'b0, 2'd0);
		queue_beat(REQ_STATUS, 1, 1'b0, 1'b0, 2'd0);
		queue_beat(REQ_TICK, 62, 1'b1, 1'b0, 2'd0);        // running slot not runnable
		queue_beat(REQ_TICK, 63, 1'b1, 1'b1, 2'd3);        // running slot itself runnable
		queue_beat(REQ_STATUS, 63, 1'b1, 1'b0, 2'd3);
		queue_beat(REQ_TICK, 63, 1'b1, 1'b0, 2'd0);
		drain();

		// Lowest register values: every slice expires, every waiting slot above level zero promotes
		set_policy(8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
		idle_pct = 25;
		queue_random(360);
		drain();

		// Highest register values, with a long receiver hold-off
		set_policy(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
		pressure_go = 1'b1;
		idle_pct = 10;
		queue_random(360);
		drain();

		set_policy(8'($urandom_range(255, 1)), 8'($urandom_range(255, 1)),
		           8'($urandom_range(255, 1)), 8'($urandom_range(255, 1)),
		           8'($urandom_range(255, 1)));
		idle_pct = 30;
		queue_random(360);
		drain();

		// Last part at full rate
		set_policy(8'd2, 8'd5, 8'd12, 8'd40, 8'd20);
		idle_pct = 0;
		queue_random(360);
		drain();

		repeat (100) @(posedge clk);
		if (errors == 0 && verdict_q.size() == 0) begin
			$display("tb_mlfq_tick_accounting_core passed");
		end else begin
			$display("tb_mlfq_tick_accounting_core failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/mtk_pkg.sv
rtl/core/mtk_cell.sv
rtl/core/mtk_head.sv
rtl/core/mlfq_tick_accounting_core.sv
rtl/core/mtk_checker.sv
sim/tb_mlfq_tick_accounting_core.sv
